// ===== src/cft_pkg.sv =====
// Package for the CSV field tokenizer: state codes, character codes and
// counter width. Used by the interfaces, the top level and the checker.
`default_nettype none

package cft_pkg;

	// Width of the line and column counters; the ports show the low 32 bits.
	localparam int POSITION_BITS = 32;
	localparam int OUT_POS_BITS  = 32;

	localparam logic [3:0] ST_INITIAL   = 4'd0;
	localparam logic [3:0] ST_COMMA     = 4'd1;
	localparam logic [3:0] ST_LF        = 4'd2;
	localparam logic [3:0] ST_CR        = 4'd3;
	localparam logic [3:0] ST_CRLF      = 4'd4;
	localparam logic [3:0] ST_UNQUOTED  = 4'd5;
	localparam logic [3:0] ST_QUOTED    = 4'd6;
	localparam logic [3:0] ST_QUOTED_CR = 4'd7;
	localparam logic [3:0] ST_PREV_QUOTE = 4'd8;
	localparam logic [3:0] ST_PREV_BSL  = 4'd9;
	localparam logic [3:0] ST_EOF       = 4'd10;
	localparam logic [3:0] ST_ERROR     = 4'd11;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	typedef logic [POSITION_BITS-1:0] pos_t;

	// Low output bits of a counter, zero-extended when the counter is narrow.
	function automatic logic [OUT_POS_BITS-1:0] pos_out(input pos_t v);
		logic [63:0] wide;
		wide = 64'(v);
		return wide[OUT_POS_BITS-1:0];
	endfunction

	function automatic pos_t sat_inc(input pos_t v);
		return (v == {POSITION_BITS{1'b1}}) ? v : v + pos_t'(1);
	endfunction

endpackage

`default_nettype wire

// ===== src/cft_if.sv =====
// Stream interfaces of the CSV field tokenizer: input bytes and token words.
// Depends on cft_pkg for the position output width.
`default_nettype none

interface cft_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       end_mark;

	modport source (output valid, output symbol, output end_mark, input ready);
	modport sink   (input valid, input symbol, input end_mark, output ready);
endinterface

interface cft_out_if import cft_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic                    emit_valid;
	logic [7:0]              emit_byte;
	logic [3:0]              parse_state;
	logic                    field_done;
	logic                    syntax_error;
	logic [OUT_POS_BITS-1:0] line_number;
	logic [OUT_POS_BITS-1:0] column_number;

	modport source (output valid, output emit_valid, output emit_byte, output parse_state,
		output field_done, output syntax_error, output line_number,
		output column_number, input ready);
	modport sink (input valid, input emit_valid, input emit_byte, input parse_state,
		input field_done, input syntax_error, input line_number,
		input column_number, output ready);
endinterface

`default_nettype wire

// ===== src/csv_field_tokenizer_unit.sv =====
// CSV field tokenizer top level: input register, tokenizer step, result register.
// Depends on cft_pkg and the stream interfaces in cft_if.sv.
//
// The block takes one input word per cycle unless the output stalls, and returns
// one token word for each, in order: the byte is captured in an input
// register, the tokenizer step and the line and column updates are evaluated
// from it and the current state, and the result lands in an output register
// while the state advances. Back-pressure on the output stalls the input
// register and then the input. Errors are sticky: once the error state (or end
// of file) is reached, only the counters keep moving until reset.
`default_nettype none

module csv_field_tokenizer_unit import cft_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cft_in_if.sink     stream,
	cft_out_if.source  tokens
);

	logic       valid_s1;
	logic [7:0] symbol_s1;
	logic       end_mark_s1;

	logic [3:0] state_q;
	pos_t       line_q;
	pos_t       column_q;

	logic       out_valid_q;
	logic       emit_valid_q;
	logic [7:0] emit_byte_q;
	logic       field_done_q;
	logic       syntax_error_q;

	logic       advance;
	logic [3:0] next_state;
	logic       push;
	pos_t       next_line;
	pos_t       next_column;

	assign advance      = valid_s1 && (!out_valid_q || tokens.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			symbol_s1   <= stream.symbol;
			end_mark_s1 <= stream.end_mark;
		end
	end

	// Counters follow the byte and the state before the transition.
	always_comb begin
		next_line   = line_q;
		next_column = column_q;
		if (!end_mark_s1) begin
			if (symbol_s1 == CH_LF) begin
				if (state_q != ST_CR && state_q != ST_QUOTED_CR) begin
					next_line   = sat_inc(line_q);
					next_column = pos_t'(1);
				end
			end else if (symbol_s1 == CH_CR) begin
				next_line   = sat_inc(line_q);
				next_column = pos_t'(1);
			end else begin
				next_column = sat_inc(column_q);
			end
		end
	end

	always_comb begin
		next_state = state_q;
		push       = 1'b0;
		case (state_q)
			ST_INITIAL, ST_COMMA, ST_LF, ST_CR, ST_CRLF: begin
				if (end_mark_s1) begin
					next_state = ST_EOF;
				end else if (state_q == ST_CR && symbol_s1 == CH_LF) begin
					next_state = ST_CRLF;
				end else if (symbol_s1 == CH_QUOTE) begin
					next_state = ST_QUOTED;
				end else if (symbol_s1 == CH_CR) begin
					next_state = ST_CR;
				end else if (symbol_s1 == CH_LF) begin
					next_state = ST_LF;
				end else begin
					next_state = ST_UNQUOTED;
					push       = 1'b1;
				end
			end
			ST_UNQUOTED: begin
				if (end_mark_s1) begin
					next_state = ST_EOF;
				end else if (symbol_s1 == CH_QUOTE) begin
					next_state = ST_ERROR;
				end else if (symbol_s1 == CH_CR) begin
					next_state = ST_CR;
				end else if (symbol_s1 == CH_LF) begin
					next_state = ST_LF;
				end else if (symbol_s1 == CH_COMMA) begin
					next_state = ST_COMMA;
				end else begin
					push = 1'b1;
				end
			end
			ST_QUOTED, ST_QUOTED_CR: begin
				if (end_mark_s1) begin
					next_state = ST_ERROR;
				end else if (symbol_s1 == CH_QUOTE) begin
					next_state = ST_PREV_QUOTE;
				end else if (symbol_s1 == CH_BSL) begin
					next_state = ST_PREV_BSL;
				end else begin
					next_state = (symbol_s1 == CH_CR) ? ST_QUOTED_CR : ST_QUOTED;
					push       = 1'b1;
				end
			end
			ST_PREV_QUOTE: begin
				if (end_mark_s1) begin
					next_state = ST_EOF;
				end else if (symbol_s1 == CH_QUOTE) begin
					next_state = ST_QUOTED;
					push       = 1'b1;
				end else if (symbol_s1 == CH_CR) begin
					next_state = ST_CR;
				end else if (symbol_s1 == CH_LF) begin
					next_state = ST_LF;
				end else if (symbol_s1 == CH_COMMA) begin
					next_state = ST_COMMA;
				end else begin
					next_state = ST_ERROR;
				end
			end
			ST_PREV_BSL: begin
				// A second backslash keeps the escape pending and emits nothing.
				if (end_mark_s1) begin
					next_state = ST_ERROR;
				end else if (symbol_s1 != CH_BSL) begin
					next_state = (symbol_s1 == CH_CR) ? ST_QUOTED_CR : ST_QUOTED;
					push       = 1'b1;
				end
			end
			default: begin
				next_state = state_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INITIAL;
			line_q      <= pos_t'(1);
			column_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= next_state;
				line_q      <= next_line;
				column_q    <= next_column;
				out_valid_q <= 1'b1;
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			emit_valid_q   <= push;
			emit_byte_q    <= push ? symbol_s1 : 8'h00;
			syntax_error_q <= (next_state >= ST_ERROR);
			field_done_q   <= (next_state inside {ST_COMMA, ST_LF, ST_CR, ST_CRLF, ST_EOF})
				|| (next_state >= ST_ERROR);
		end
	end

	assign tokens.valid         = out_valid_q;
	assign tokens.emit_valid    = emit_valid_q;
	assign tokens.emit_byte     = emit_byte_q;
	assign tokens.parse_state   = state_q;
	assign tokens.field_done    = field_done_q;
	assign tokens.syntax_error  = syntax_error_q;
	assign tokens.line_number   = pos_out(line_q);
	assign tokens.column_number = pos_out(column_q);

endmodule

`default_nettype wire

// ===== src/cft_checker.sv =====
// Port-level checks for the CSV field tokenizer, bound to the top level.
// Depends on cft_pkg for state codes and the position output width.
`default_nettype none

module cft_checker import cft_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic                    emit_valid,
	input wire logic [7:0]              emit_byte,
	input wire logic [3:0]              parse_state,
	input wire logic                    field_done,
	input wire logic                    syntax_error,
	input wire logic [OUT_POS_BITS-1:0] line_number,
	input wire logic [OUT_POS_BITS-1:0] column_number
);

	logic error_seen_q;

	// Remembers that an error word has been delivered since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_seen_q <= 1'b0;
		end else if (out_valid && out_ready && syntax_error) begin
			error_seen_q <= 1'b1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(parse_state)
			&& $stable(line_number) && $stable(column_number) && $stable(emit_byte))
		else $error("token word changed while stalled");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_seen_q |-> syntax_error && parse_state == ST_ERROR)
		else $error("parser left the error state");

	a_error_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && syntax_error |-> field_done && !emit_valid)
		else $error("error word without field end or with a data byte");

	a_emit_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && emit_valid |-> !field_done && (parse_state == ST_UNQUOTED
			|| parse_state == ST_QUOTED || parse_state == ST_QUOTED_CR))
		else $error("data byte emitted outside a field");

	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !emit_valid |-> emit_byte == 8'h00 && line_number != '0)
		else $error("stray data byte or zero line number");

endmodule

bind csv_field_tokenizer_unit cft_checker u_cft_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (tokens.valid),
	.out_ready     (tokens.ready),
	.emit_valid    (tokens.emit_valid),
	.emit_byte     (tokens.emit_byte),
	.parse_state   (tokens.parse_state),
	.field_done    (tokens.field_done),
	.syntax_error  (tokens.syntax_error),
	.line_number   (tokens.line_number),
	.column_number (tokens.column_number)
);

`default_nettype wire

// ===== tb/csv_field_tokenizer_unit_tb.sv =====
// Self-checking bench for the CSV field tokenizer: a directed table of bytes, then a long
// state-aware random stream that closes with one terminal case. Needs cft_pkg, cft_if.sv
// and csv_field_tokenizer_unit.sv.
module csv_field_tokenizer_unit_tb import cft_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT  = 1000;
	localparam int RANDOM_WORDS = 1200;
	localparam int DRAIN_AT     = 600;
	localparam int LONG_HOLD_AT = 500;

	typedef struct packed {
		logic                    emit_valid;
		logic [7:0]              emit_byte;
		logic [3:0]              parse_state;
		logic                    field_done;
		logic                    syntax_error;
		logic [OUT_POS_BITS-1:0] line_number;
		logic [OUT_POS_BITS-1:0] column_number;
	} token_t;

	typedef struct packed {
		logic [3:0] st;
		pos_t       line;
		pos_t       col;
	} scan_ctx_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_mark;
		logic       typed;
		token_t     tok;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	cft_in_if  in_bus ();
	cft_out_if out_bus ();

	csv_field_tokenizer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (in_bus),
		.tokens (out_bus)
	);

	always #5 clk = ~clk;

	stim_row_t   pending_words[$];
	token_t      expected_tokens[$];
	scan_ctx_t   gen_ctx;
	scan_ctx_t   pred_ctx;
	bit          calm;
	int          fail_count;
	int          words_accepted;
	int          tokens_checked;
	int          content_bytes;
	int          field_ends;
	int          quiet_cycles;
	logic [15:0] states_seen;

	function automatic pos_t bump(input pos_t v);
		return (&v) ? v : v + pos_t'(1);
	endfunction

	// One tokenizer step: advances ctx and returns the word the block should produce.
	function automatic token_t tokenize_step(inout scan_ctx_t ctx, input logic [7:0] c,
		input logic eom);
		token_t     t;
		logic [3:0] nxt;
		logic       push;
		nxt  = ctx.st;
		push = 1'b0;
		// The counters follow the byte and the state it arrives in.
		if (!eom) begin
			if (c == CH_LF) begin
				if (ctx.st != ST_CR && ctx.st != ST_QUOTED_CR) begin
					ctx.line = bump(ctx.line);
					ctx.col  = pos_t'(1);
				end
			end else if (c == CH_CR) begin
				ctx.line = bump(ctx.line);
				ctx.col  = pos_t'(1);
			end else begin
				ctx.col = bump(ctx.col);
			end
		end
		case (ctx.st)
			ST_INITIAL, ST_COMMA, ST_LF, ST_CR, ST_CRLF: begin
				if (ctx.st == ST_CR && !eom && c == CH_LF) nxt = ST_CRLF;
				else if (eom) nxt = ST_EOF;
				else if (c == CH_QUOTE) nxt = ST_QUOTED;
				else if (c == CH_CR) nxt = ST_CR;
				else if (c == CH_LF) nxt = ST_LF;
				else begin
					nxt  = ST_UNQUOTED;
					push = 1'b1;
				end
			end
			ST_UNQUOTED: begin
				if (eom) nxt = ST_EOF;
				else if (c == CH_QUOTE) nxt = ST_ERROR;
				else if (c == CH_CR) nxt = ST_CR;
				else if (c == CH_LF) nxt = ST_LF;
				else if (c == CH_COMMA) nxt = ST_COMMA;
				else push = 1'b1;
			end
			ST_QUOTED, ST_QUOTED_CR: begin
				if (eom) nxt = ST_ERROR;
				else if (c == CH_QUOTE) nxt = ST_PREV_QUOTE;
				else if (c == CH_BSL) nxt = ST_PREV_BSL;
				else begin
					nxt  = (c == CH_CR) ? ST_QUOTED_CR : ST_QUOTED;
					push = 1'b1;
				end
			end
			ST_PREV_QUOTE: begin
				if (eom) nxt = ST_EOF;
				else if (c == CH_QUOTE) begin
					nxt  = ST_QUOTED;
					push = 1'b1;
				end
				else if (c == CH_CR) nxt = ST_CR;
				else if (c == CH_LF) nxt = ST_LF;
				else if (c == CH_COMMA) nxt = ST_COMMA;
				else nxt = ST_ERROR;
			end
			ST_PREV_BSL: begin
				if (eom) nxt = ST_ERROR;
				else if (c == CH_BSL) nxt = ST_PREV_BSL;
				else begin
					nxt  = (c == CH_CR) ? ST_QUOTED_CR : ST_QUOTED;
					push = 1'b1;
				end
			end
			default: nxt = ctx.st;
		endcase
		ctx.st         = nxt;
		t.emit_valid   = push;
		t.emit_byte    = push ? c : 8'h00;
		t.parse_state  = nxt;
		t.syntax_error = (nxt >= ST_ERROR);
		t.field_done   = t.syntax_error || (nxt inside {ST_COMMA, ST_LF, ST_CR, ST_CRLF, ST_EOF});
		t.line_number  = OUT_POS_BITS'(ctx.line);
		t.column_number = OUT_POS_BITS'(ctx.col);
		return t;
	endfunction

	function automatic stim_row_t word_row(input logic [7:0] sym, input logic eom);
		stim_row_t r;
		r          = '0;
		r.symbol   = sym;
		r.end_mark = eom;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic [7:0] sym, input token_t tok);
		stim_row_t r;
		r       = word_row(sym, 1'b0);
		r.typed = 1'b1;
		r.tok   = tok;
		return r;
	endfunction

	// Favors the special characters, and never picks a byte that would end the run early.
	function automatic logic [7:0] pick_symbol(input scan_ctx_t ctx);
		logic [7:0] c;
		scan_ctx_t  trial;
		token_t     t;
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(0, 9))
				0:       c = CH_QUOTE;
				1:       c = CH_COMMA;
				2:       c = CH_CR;
				3:       c = CH_LF;
				4:       c = CH_BSL;
				default: c = 8'($urandom_range(0, 255));
			endcase
			trial = ctx;
			t     = tokenize_step(trial, c, 1'b0);
			if (t.parse_state < ST_EOF) return c;
		end
		// A comma is legal in every open state.
		return CH_COMMA;
	endfunction

	task automatic send_word(input stim_row_t row);
		token_t unused;
		unused = tokenize_step(gen_ctx, row.symbol, row.end_mark);
		pending_words.push_back(row);
		in_bus.valid    <= 1'b1;
		in_bus.symbol   <= row.symbol;
		in_bus.end_mark <= row.end_mark;
		@(posedge clk);
		while (!in_bus.ready) @(posedge clk);
	endtask

	task automatic source_gap(input int cycles);
		in_bus.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_gap(input int idx);
		if (!calm && (idx / 150) % 3 != 2 && $urandom_range(0, 4) == 0)
			source_gap($urandom_range(1, 9));
	endtask

	task automatic wait_drained();
		in_bus.valid <= 1'b0;
		do @(posedge clk); while (expected_tokens.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Prediction at input acceptance, comparison at output acceptance.
	always @(posedge clk) begin
		token_t    pred;
		token_t    want;
		stim_row_t row;
		if (in_bus.valid && in_bus.ready) begin
			pred = tokenize_step(pred_ctx, in_bus.symbol, in_bus.end_mark);
			row  = pending_words.pop_front();
			expected_tokens.push_back(row.typed ? row.tok : pred);
			words_accepted++;
		end
		if (out_bus.valid && out_bus.ready) begin
			tokens_checked++;
			if (expected_tokens.size() == 0) begin
				$display("%0t ns: token word with nothing expected, state 0x%0h", $time,
					out_bus.parse_state);
				fail_count++;
			end else begin
				want = expected_tokens.pop_front();
				check_field("emit_valid", 32'(want.emit_valid), 32'(out_bus.emit_valid));
				check_field("emit_byte", 32'(want.emit_byte), 32'(out_bus.emit_byte));
				check_field("parse_state", 32'(want.parse_state), 32'(out_bus.parse_state));
				check_field("field_done", 32'(want.field_done), 32'(out_bus.field_done));
				check_field("syntax_error", 32'(want.syntax_error), 32'(out_bus.syntax_error));
				check_field("line_number", 32'(want.line_number), 32'(out_bus.line_number));
				check_field("column_number", 32'(want.column_number),
					32'(out_bus.column_number));
			end
			if (out_bus.emit_valid === 1'b1) content_bytes++;
			if (out_bus.field_done === 1'b1) field_ends++;
			if (!$isunknown(out_bus.parse_state)) states_seen[out_bus.parse_state] = 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n === 1'b1) begin
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : sink_side
		int hold_left;
		bit long_hold_done;
		hold_left      = 0;
		long_hold_done = 1'b0;
		out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_bus.ready <= 1'b0;
			end else if (!long_hold_done && words_accepted >= LONG_HOLD_AT) begin
				// Long back-pressure so the block fills and stalls its input.
				long_hold_done = 1'b1;
				hold_left      = 59;
				out_bus.ready <= 1'b0;
			end else if (calm || (words_accepted / 100) % 3 == 1) begin
				out_bus.ready <= 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				hold_left      = $urandom_range(0, 8);
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : source_side
		stim_row_t directed [25];
		int        ending;
		string     ending_name;
		fail_count      = 0;
		words_accepted  = 0;
		tokens_checked  = 0;
		content_bytes   = 0;
		field_ends      = 0;
		quiet_cycles    = 0;
		states_seen     = '0;
		calm            = 1'b0;
		gen_ctx         = '{st: ST_INITIAL, line: pos_t'(1), col: '0};
		pred_ctx        = gen_ctx;
		in_bus.valid    <= 1'b0;
		in_bus.symbol   <= 8'h00;
		in_bus.end_mark <= 1'b0;
		arst_n          <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			typed_row(8'h00, token_t'{1'b1, 8'h00, ST_UNQUOTED, 1'b0, 1'b0, 32'd1, 32'd1}),
			typed_row(8'hFF, token_t'{1'b1, 8'hFF, ST_UNQUOTED, 1'b0, 1'b0, 32'd1, 32'd2}),
			typed_row(CH_COMMA, token_t'{1'b0, 8'h00, ST_COMMA, 1'b1, 1'b0, 32'd1, 32'd3}),
			word_row(CH_QUOTE, 1'b0), word_row(CH_COMMA, 1'b0),
			// A second backslash keeps the escape pending.
			word_row(CH_BSL, 1'b0), word_row(CH_BSL, 1'b0), word_row(8'h6E, 1'b0),
			word_row(CH_BSL, 1'b0), word_row(CH_CR, 1'b0), word_row(CH_LF, 1'b0),
			word_row(CH_CR, 1'b0), word_row(8'h61, 1'b0),
			word_row(CH_QUOTE, 1'b0), word_row(CH_QUOTE, 1'b0), word_row(CH_QUOTE, 1'b0),
			word_row(CH_CR, 1'b0), word_row(CH_LF, 1'b0), word_row(8'h78, 1'b0),
			word_row(CH_CR, 1'b0), word_row(CH_CR, 1'b0),
			word_row(CH_QUOTE, 1'b0), word_row(CH_QUOTE, 1'b0),
			word_row(CH_LF, 1'b0), word_row(CH_LF, 1'b0)
		};
		foreach (directed[i]) begin
			maybe_gap(i);
			send_word(directed[i]);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == DRAIN_AT) wait_drained();
			maybe_gap(i);
			send_word(word_row(pick_symbol(gen_ctx), 1'b0));
		end

		// Closing part: no idling, bring the parser to a field start, then end it for good.
		calm = 1'b1;
		while (!(gen_ctx.st inside {ST_INITIAL, ST_COMMA, ST_LF, ST_CR, ST_CRLF})) begin
			if (gen_ctx.st inside {ST_QUOTED, ST_QUOTED_CR}) send_word(word_row(CH_QUOTE, 1'b0));
			else if (gen_ctx.st == ST_PREV_BSL) send_word(word_row(8'h61, 1'b0));
			else send_word(word_row(CH_COMMA, 1'b0));
		end
		ending = $urandom_range(0, 4);
		case (ending)
			0: begin
				ending_name = "end of file";
				send_word(word_row(8'($urandom_range(0, 255)), 1'b1));
			end
			1: begin
				ending_name = "a quote inside an unquoted field";
				send_word(word_row(8'h61, 1'b0));
				send_word(word_row(CH_QUOTE, 1'b0));
			end
			2: begin
				ending_name = "a stray byte after a closing quote";
				send_word(word_row(CH_QUOTE, 1'b0));
				send_word(word_row(8'h61, 1'b0));
				send_word(word_row(CH_QUOTE, 1'b0));
				send_word(word_row(8'h62, 1'b0));
			end
			3: begin
				ending_name = "end of file inside quotes";
				send_word(word_row(CH_QUOTE, 1'b0));
				send_word(word_row(8'($urandom_range(0, 255)), 1'b1));
			end
			default: begin
				ending_name = "end of file after a backslash";
				send_word(word_row(CH_QUOTE, 1'b0));
				send_word(word_row(CH_BSL, 1'b0));
				send_word(word_row(8'($urandom_range(0, 255)), 1'b1));
			end
		endcase
		// The state is frozen now, but the counters keep following the bytes.
		repeat (20) send_word(word_row(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));

		wait_drained();
		repeat (4) @(posedge clk);

		$display("Checked %0d words from %0d inputs: %0d content bytes, %0d field ends.",
			tokens_checked, words_accepted, content_bytes, field_ends);
		$display("State codes seen 0x%04h; the stream was closed by %s.", states_seen,
			ending_name);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
